>>> rtl/core/biq_pkg.sv
// biq_pkg: shared types, constants and helpers of the biquad cascade filter
`timescale 1ns / 1ps

package biq_pkg;

    // defaults of the top-level parameters
    localparam int MAX_SECTIONS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int COEF_BITS_DEF    = 24;

    // fixed formats
    localparam int NCOEF   = 5;   // b0 b1 b2 a1 a2 per section
    localparam int WFRAC   = 8;   // fractional bits of the internal words
    localparam int WORD_W  = 32;  // delay words and section outputs
    localparam int RND_W   = 37;  // rounded product, independent of coefficient width
    localparam int ACC_W   = RND_W + 2;
    localparam int FUNC_W  = 2;
    localparam int STAGE_W = 3;
    localparam int SEL_W   = 3;
    localparam int CFG_W   = 4;

    // item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_COEF   = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    // coefficient operations, coded as the coefficient select value
    typedef enum logic [SEL_W-1:0] {
        OP_B0 = 3'd0,
        OP_B1 = 3'd1,
        OP_B2 = 3'd2,
        OP_A1 = 3'd3,
        OP_A2 = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    // tag that travels with a product through the multiply pipeline
    typedef struct packed {
        logic vld;
        op_t  op;
    } tag_t;

    // issue order within one section: a1 a2 b1 b2 b0
    function automatic op_t next_op(op_t op);
        op_t nxt;
        unique case (op)
            OP_A1:   nxt = OP_A2;
            OP_A2:   nxt = OP_B1;
            OP_B1:   nxt = OP_B2;
            OP_B2:   nxt = OP_B0;
            OP_B0:   nxt = OP_A1;
            default: nxt = OP_A1;
        endcase
        return nxt;
    endfunction

    function automatic logic word_ovf(logic signed [ACC_W-1:0] x);
        return x[ACC_W-1:WORD_W-1] != {(ACC_W-WORD_W+1){x[WORD_W-1]}};
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(logic signed [ACC_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (!word_ovf(x))
            r = x[WORD_W-1:0];
        else if (x[ACC_W-1])
            r = {1'b1, {(WORD_W-1){1'b0}}};
        else
            r = {1'b0, {(WORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> rtl/core/biquad_cascade_iir_filter.sv
// biquad_cascade_iir_filter: cascade of direct-form-II biquad sections, top level
`timescale 1ns / 1ps
//
// channel   direction  handshake            contents
// s_*       in         s_tvalid / s_tready  tuser: func; tdata: sample_in, stage_index,
//                                           coef_select, coef_value
// m_*       out        m_tvalid / m_tready  tuser: clipped; tdata: sample_out
// cfg_*     in         cfg_valid / cfg_ready active_stages write, always ready
//
// a sample transaction passes through the n active sections in turn before
// the result transaction is offered (straight to the output register when
// n is zero); the single shared multiplier does the five products of each
// section one per cycle, so it sets the rate
// coefficient and clear transactions complete in their acceptance cycle
// coefficient and delay memories carry per-entry valid bits, so reset needs
// no clearing pass; a clear transaction drops the delay valid bits at once
// a result waiting in the output register does not block acceptance; only
// the end of the following sample waits for it to be taken

module biquad_cascade_iir_filter #(
    parameter int MAX_SECTIONS = biq_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS  = biq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS    = biq_pkg::COEF_BITS_DEF,
    localparam int S_TDATA_W   = ((SAMPLE_BITS + biq_pkg::STAGE_W + biq_pkg::SEL_W
                                   + COEF_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,  // sample_in, stage_index, coef_select, coef_value
    input  logic [biq_pkg::FUNC_W-1:0]    s_tuser,  // func
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,  // sample_out
    output logic                          m_tuser,  // clipped
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [biq_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_SECTIONS + 1);
    localparam int CDEPTH  = biq_pkg::NCOEF * MAX_SECTIONS;
    localparam int CADDR_W = $clog2(CDEPTH);
    localparam int CFRAC   = COEF_BITS - 4;
    localparam int WORD_W  = biq_pkg::WORD_W;
    localparam int ACC_W   = biq_pkg::ACC_W;
    localparam int OFF_STG = SAMPLE_BITS;
    localparam int OFF_SEL = OFF_STG + biq_pkg::STAGE_W;
    localparam int OFF_CF  = OFF_SEL + biq_pkg::SEL_W;
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << CFRAC;

    // ---------------------------------------------------------------------
    // input field unpacking
    // ---------------------------------------------------------------------
    biq_pkg::func_t                item_func;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [biq_pkg::STAGE_W-1:0]   stage_index;
    logic [biq_pkg::SEL_W-1:0]     coef_select;
    logic [COEF_BITS-1:0]          coef_value;

    assign item_func   = biq_pkg::func_t'(s_tuser);
    assign sample_in   = s_tdata[SAMPLE_BITS-1:0];
    assign stage_index = s_tdata[OFF_STG +: biq_pkg::STAGE_W];
    assign coef_select = s_tdata[OFF_SEL +: biq_pkg::SEL_W];
    assign coef_value  = s_tdata[OFF_CF +: COEF_BITS];

    // ---------------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------------
    logic [biq_pkg::CFG_W-1:0] active_reg;
    logic [CNT_W-1:0]          n_eff;

    assign cfg_ready = 1'b1;
    // a count beyond the built sections uses all of them
    assign n_eff = (int'(active_reg) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                     : CNT_W'(active_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (cfg_valid && cfg_ready)
            active_reg <= cfg_data;
    end

    // ---------------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------------
    biq_pkg::state_t state_reg;
    biq_pkg::state_t state_next;
    logic            take_item;
    logic            out_free;
    logic            out_load;
    logic            last_done;

    logic                 iss_on_reg;
    biq_pkg::op_t         iss_op_reg;
    logic [IDX_W-1:0]     iss_sec_reg;
    logic [IDX_W-1:0]     comb_sec_reg;
    logic [CNT_W-1:0]     n_reg;
    biq_pkg::tag_t        d_tag_reg;
    biq_pkg::tag_t        r_tag;
    logic                 clip_reg;

    assign s_tready  = (state_reg == biq_pkg::ST_IDLE);
    assign take_item = s_tvalid && s_tready;
    assign out_free  = !m_tvalid || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= biq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                if (take_item && item_func == biq_pkg::FUNC_SAMPLE)
                    state_next = (n_eff == '0) ? biq_pkg::ST_OUT : biq_pkg::ST_RUN;
            end
            biq_pkg::ST_RUN:
            begin
                if (last_done)
                    state_next = biq_pkg::ST_OUT;
            end
            biq_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = biq_pkg::ST_IDLE;
                end
            end
            default:
                state_next = biq_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // coefficient memory, one synchronous read port, one write port
    // entries never written read as b0 = 1.0, others zero
    // ---------------------------------------------------------------------
    logic [COEF_BITS-1:0] coef_mem [CDEPTH];
    logic [CDEPTH-1:0]    cvalid_reg;
    logic                 coef_we;
    logic [CADDR_W-1:0]   coef_waddr;
    logic [CADDR_W-1:0]   coef_raddr;
    logic [COEF_BITS-1:0] coef_rd_reg;
    logic                 cvld_rd_reg;

    assign coef_we = take_item && item_func == biq_pkg::FUNC_COEF
                     && int'(stage_index) < MAX_SECTIONS
                     && int'(coef_select) < biq_pkg::NCOEF;
    assign coef_waddr = CADDR_W'(stage_index) * CADDR_W'(biq_pkg::NCOEF)
                        + CADDR_W'(coef_select);
    assign coef_raddr = CADDR_W'(iss_sec_reg) * CADDR_W'(biq_pkg::NCOEF)
                        + CADDR_W'(iss_op_reg);

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_value;
        if (iss_on_reg)
            coef_rd_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg  <= '0;
            cvld_rd_reg <= 1'b0;
        end
        else
        begin
            if (coef_we)
                cvalid_reg[coef_waddr] <= 1'b1;
            if (iss_on_reg)
                cvld_rd_reg <= cvalid_reg[coef_raddr];
        end
    end

    // ---------------------------------------------------------------------
    // delay memory: one row per section, {delay_one, delay_two}
    // read when a section's first product issues, written back once w is known
    // ---------------------------------------------------------------------
    logic [2*WORD_W-1:0] dly_mem [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] dvalid_reg;
    logic                dly_re;
    logic                dly_we;
    logic [2*WORD_W-1:0] dly_rd_reg;
    logic                dvld_rd_reg;
    logic signed [WORD_W-1:0] v1;
    logic signed [WORD_W-1:0] v2;
    logic signed [WORD_W-1:0] w_next;

    assign dly_re = iss_on_reg && iss_op_reg == biq_pkg::OP_A1;
    assign dly_we = r_tag.vld && r_tag.op == biq_pkg::OP_A2;
    assign v1     = dvld_rd_reg ? dly_rd_reg[2*WORD_W-1:WORD_W] : '0;
    assign v2     = dvld_rd_reg ? dly_rd_reg[WORD_W-1:0]        : '0;

    always_ff @(posedge clk)
    begin
        if (dly_we)
            dly_mem[comb_sec_reg] <= {w_next, v1};
        if (dly_re)
            dly_rd_reg <= dly_mem[iss_sec_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg  <= '0;
            dvld_rd_reg <= 1'b0;
        end
        else
        begin
            // clear transactions only arrive while idle, write-back only while running
            if (take_item && item_func == biq_pkg::FUNC_CLEAR)
                dvalid_reg <= '0;
            else if (dly_we)
                dvalid_reg[comb_sec_reg] <= 1'b1;
            if (dly_re)
                dvld_rd_reg <= dvalid_reg[iss_sec_reg];
        end
    end

    // ---------------------------------------------------------------------
    // multiply stage: coefficient and operand by the op tag
    // ---------------------------------------------------------------------
    logic signed [COEF_BITS-1:0]       coef_eff;
    logic signed [WORD_W-1:0]          mul_word;
    logic signed [biq_pkg::RND_W-1:0]  rnd;
    logic signed [WORD_W-1:0]          w_reg;

    always_comb
    begin
        if (cvld_rd_reg)
            coef_eff = coef_rd_reg;
        else if (d_tag_reg.op == biq_pkg::OP_B0)
            coef_eff = COEF_ONE;
        else
            coef_eff = '0;
        case (d_tag_reg.op) inside
            biq_pkg::OP_A1, biq_pkg::OP_B1: mul_word = v1;
            biq_pkg::OP_A2, biq_pkg::OP_B2: mul_word = v2;
            biq_pkg::OP_B0:                 mul_word = w_reg;
            default:                        mul_word = '0;
        endcase
    end

    biq_mul #(
        .COEF_BITS (COEF_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .coef    (coef_eff),
        .word    (mul_word),
        .tag_in  (d_tag_reg),
        .rnd     (rnd),
        .tag_out (r_tag)
    );

    // ---------------------------------------------------------------------
    // combine stage: w = v - a1*v1 - a2*v2, y = b1*v1 + b2*v2 + b0*w
    // ---------------------------------------------------------------------
    logic signed [WORD_W-1:0] v_reg;
    logic signed [ACC_W-1:0]  wacc_reg;
    logic signed [ACC_W-1:0]  yacc_reg;
    logic signed [ACC_W-1:0]  rnd_ext;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  y_sum;
    logic signed [WORD_W-1:0] y_next;
    logic                     w_ovf;
    logic                     y_ovf;

    assign rnd_ext   = ACC_W'(rnd);
    assign w_sum     = wacc_reg - rnd_ext;
    assign y_sum     = yacc_reg + rnd_ext;
    assign w_next    = biq_pkg::sat_word(w_sum);
    assign w_ovf     = biq_pkg::word_ovf(w_sum);
    assign y_next    = biq_pkg::sat_word(y_sum);
    assign y_ovf     = biq_pkg::word_ovf(y_sum);
    assign last_done = r_tag.vld && r_tag.op == biq_pkg::OP_B0
                       && CNT_W'(comb_sec_reg) == n_reg - CNT_W'(1);

    // ---------------------------------------------------------------------
    // final rounding back to sample scale and saturation
    // ---------------------------------------------------------------------
    logic signed [WORD_W:0]        fin_sum;
    logic signed [WORD_W:0]        fin_q;
    logic                          fin_ovf;
    logic signed [SAMPLE_BITS-1:0] fin_sample;

    assign fin_sum = (WORD_W+1)'(v_reg) + (WORD_W+1)'(1 << (biq_pkg::WFRAC - 1));
    assign fin_q   = fin_sum >>> biq_pkg::WFRAC;
    assign fin_ovf = fin_q[WORD_W:SAMPLE_BITS-1]
                     != {(WORD_W-SAMPLE_BITS+2){fin_q[SAMPLE_BITS-1]}};

    always_comb
    begin
        if (!fin_ovf)
            fin_sample = fin_q[SAMPLE_BITS-1:0];
        else if (fin_q[WORD_W])
            fin_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            fin_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    // ---------------------------------------------------------------------
    // sequencer: issues five coefficient reads per section, one per cycle
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_on_reg   <= 1'b0;
            iss_op_reg   <= biq_pkg::OP_A1;
            iss_sec_reg  <= '0;
            comb_sec_reg <= '0;
            n_reg        <= '0;
            d_tag_reg    <= '0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            d_tag_reg.vld <= iss_on_reg;
            d_tag_reg.op  <= iss_op_reg;
            if (take_item && item_func == biq_pkg::FUNC_SAMPLE)
            begin
                n_reg        <= n_eff;
                iss_on_reg   <= (n_eff != '0);
                iss_op_reg   <= biq_pkg::OP_A1;
                iss_sec_reg  <= '0;
                comb_sec_reg <= '0;
                clip_reg     <= 1'b0;
            end
            else
            begin
                if (iss_on_reg)
                begin
                    iss_op_reg <= biq_pkg::next_op(iss_op_reg);
                    if (iss_op_reg == biq_pkg::OP_B0)
                    begin
                        if (CNT_W'(iss_sec_reg) == n_reg - CNT_W'(1))
                            iss_on_reg <= 1'b0;
                        else
                            iss_sec_reg <= iss_sec_reg + 1'b1;
                    end
                end
                if (r_tag.vld && r_tag.op == biq_pkg::OP_B0 && !last_done)
                    comb_sec_reg <= comb_sec_reg + 1'b1;
                if (dly_we && w_ovf)
                    clip_reg <= 1'b1;
                if (r_tag.vld && r_tag.op == biq_pkg::OP_B0 && y_ovf)
                    clip_reg <= 1'b1;
            end
        end
    end

    // datapath words, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_item && item_func == biq_pkg::FUNC_SAMPLE)
            v_reg <= WORD_W'(sample_in) <<< biq_pkg::WFRAC;
        else if (r_tag.vld)
        begin
            case (r_tag.op)
                biq_pkg::OP_A1: wacc_reg <= ACC_W'(v_reg) - rnd_ext;
                biq_pkg::OP_A2: w_reg    <= w_next;
                biq_pkg::OP_B1: yacc_reg <= rnd_ext;
                biq_pkg::OP_B2: yacc_reg <= y_sum;
                biq_pkg::OP_B0: v_reg    <= y_next;
                default:        w_reg    <= w_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;
    logic                   out_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= fin_sample;
            out_clip_reg <= clip_reg || fin_ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);
    assign m_tuser  = out_clip_reg;

endmodule

>>> rtl/core/biq_mul.sv
// biq_mul: shared coefficient multiplier with product rounding pipeline
`timescale 1ns / 1ps

module biq_mul #(
    parameter int COEF_BITS = biq_pkg::COEF_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [COEF_BITS-1:0]            coef,
    input  logic signed [biq_pkg::WORD_W-1:0]      word,
    input  biq_pkg::tag_t                          tag_in,
    output logic signed [biq_pkg::RND_W-1:0]       rnd,
    output biq_pkg::tag_t                          tag_out
);

    localparam int PROD_W = COEF_BITS + biq_pkg::WORD_W;
    localparam int CFRAC  = COEF_BITS - 4;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (CFRAC - 1);

    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [PROD_W-1:0]         prod_next;
    logic signed [PROD_W-1:0]         shifted;
    logic signed [biq_pkg::RND_W-1:0] rnd_reg;
    logic signed [biq_pkg::RND_W-1:0] rnd_next;
    biq_pkg::tag_t                    ptag_reg;
    biq_pkg::tag_t                    rtag_reg;

    assign prod_next = coef * word;
    // round half up, then floor shift back to word scale
    assign shifted   = (prod_reg + HALF) >>> CFRAC;
    assign rnd_next  = shifted[biq_pkg::RND_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptag_reg <= '0;
            rtag_reg <= '0;
        end
        else
        begin
            ptag_reg <= tag_in;
            rtag_reg <= ptag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
    end

    assign rnd     = rnd_reg;
    assign tag_out = rtag_reg;

endmodule

>>> rtl/core/biq_chk.sv
// biq_chk: port-level checker for the biquad cascade filter, with its bind
`timescale 1ns / 1ps

module biq_chk #(
    parameter int M_TDATA_W = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [biq_pkg::FUNC_W-1:0] s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [M_TDATA_W-1:0]       m_tdata,
    input logic                       m_tuser
);

    logic sample_taken;
    logic other_taken;

    assign sample_taken = s_tvalid && s_tready && s_tuser == biq_pkg::FUNC_SAMPLE;
    assign other_taken  = s_tvalid && s_tready && s_tuser != biq_pkg::FUNC_SAMPLE;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a sample keeps the block busy for at least the next cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_taken |=> !s_tready)
        else $error("input ready right after a sample transaction");

    // coefficient, clear and unknown transactions finish at once
    a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
        other_taken |=> s_tready)
        else $error("input not ready after a non-sample transaction");

    // a new result appears only at the end of sample work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind biquad_cascade_iir_filter biq_chk #(
    .M_TDATA_W (M_TDATA_W)
) u_biq_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_biquad_cascade_iir_filter.sv
// tb_biquad_cascade_iir_filter: self-checking testbench of the biquad cascade filter
`timescale 1ns / 1ps

module tb_biquad_cascade_iir_filter;

    localparam int MAX_SECTIONS = biq_pkg::MAX_SECTIONS_DEF;
    localparam int SAMPLE_BITS  = biq_pkg::SAMPLE_BITS_DEF;
    localparam int COEF_BITS    = biq_pkg::COEF_BITS_DEF;
    localparam int FUNC_W       = biq_pkg::FUNC_W;
    localparam int STAGE_W      = biq_pkg::STAGE_W;
    localparam int SEL_W        = biq_pkg::SEL_W;
    localparam int CFG_W        = biq_pkg::CFG_W;
    localparam int NCOEF        = biq_pkg::NCOEF;
    localparam int WFRAC        = biq_pkg::WFRAC;
    localparam int CFRAC        = COEF_BITS - 4;
    localparam int S_TDATA_W    = ((SAMPLE_BITS + STAGE_W + SEL_W + COEF_BITS + 7) / 8) * 8;
    localparam int S_FIELDS_W   = SAMPLE_BITS + STAGE_W + SEL_W + COEF_BITS;
    localparam int M_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;  // kind the block ignores
    localparam logic [SEL_W-1:0]  SEL_BAD_LO   = 3'd5;  // selectors past a2 are ignored
    localparam logic [SEL_W-1:0]  SEL_BAD_HI   = 3'd7;
    localparam logic [CFG_W-1:0]  STAGES_TOP   = 4'd15;

    localparam longint Q_ONE   = longint'(1) << CFRAC;
    localparam longint W_HI    = 64'sd2147483647;
    localparam longint W_LO    = -64'sd2147483648;
    localparam longint S_HI    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint S_LO    = -S_HI - 1;
    localparam int DRAIN_CYCLES   = 5 * MAX_SECTIONS + 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 105;

    typedef struct {
        logic [FUNC_W-1:0]             func;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [STAGE_W-1:0]            stage_index;
        logic [SEL_W-1:0]              coef_select;
        logic signed [COEF_BITS-1:0]   coef_value;
    } biq_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_out;
        logic                   clipped;
    } biq_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // sample_in, stage_index, coef_select, coef_value
    logic [FUNC_W-1:0]     s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // sample_out
    logic                  m_tuser;   // clipped
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    // filter state as the block should hold it
    longint      coef_q  [MAX_SECTIONS][NCOEF];
    int          dly_one [MAX_SECTIONS];
    int          dly_two [MAX_SECTIONS];
    logic [CFG_W-1:0] stages_cfg;

    biq_result_t expected_out[$];
    int          fail_count;
    int          stall_cycles;
    int          burst_left;

    biquad_cascade_iir_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- filter math

    function automatic longint q_mul(input longint c, input longint v);
        return (c * v + (longint'(1) << (CFRAC - 1))) >>> CFRAC;
    endfunction

    function automatic longint clamp(input longint x, input longint lo, input longint hi,
                                     inout logic clip);
        if (x > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        if (x < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic void reset_filter_state();
        int s;
        int c;
        for (s = 0; s < MAX_SECTIONS; s++)
        begin
            for (c = 0; c < NCOEF; c++)
                coef_q[s][c] = (c == biq_pkg::OP_B0) ? Q_ONE : 0;
            dly_one[s] = 0;
            dly_two[s] = 0;
        end
        stages_cfg = '0;
    endfunction

    // runs one sample through the cascade, updating the delay words
    function automatic biq_result_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x);
        biq_result_t r;
        longint v;
        longint w;
        longint v1;
        longint v2;
        longint y;
        logic   clip;
        int     n;
        int     i;
        clip = 1'b0;
        n = (stages_cfg > MAX_SECTIONS) ? MAX_SECTIONS : int'(stages_cfg);
        if (n == 0)
        begin
            r.sample_out = x;
            r.clipped    = 1'b0;
            return r;
        end
        v = longint'(x) <<< WFRAC;
        for (i = 0; i < n; i++)
        begin
            v1 = dly_one[i];
            v2 = dly_two[i];
            w = clamp(v - q_mul(coef_q[i][biq_pkg::OP_A1], v1)
                      - q_mul(coef_q[i][biq_pkg::OP_A2], v2), W_LO, W_HI, clip);
            v = clamp(q_mul(coef_q[i][biq_pkg::OP_B0], w) + q_mul(coef_q[i][biq_pkg::OP_B1], v1)
                      + q_mul(coef_q[i][biq_pkg::OP_B2], v2), W_LO, W_HI, clip);
            dly_two[i] = int'(v1);
            dly_one[i] = int'(w);
        end
        y = (v + (longint'(1) << (WFRAC - 1))) >>> WFRAC;
        y = clamp(y, S_LO, S_HI, clip);
        r.sample_out = y[SAMPLE_BITS-1:0];
        r.clipped    = clip;
        return r;
    endfunction

    // applies one accepted transaction to the filter state
    function automatic void apply_item(input biq_item_t it);
        int s;
        case (it.func)
            biq_pkg::FUNC_SAMPLE:
                expected_out.push_back(filter_sample(it.sample_in));
            biq_pkg::FUNC_COEF:
                if (it.stage_index < MAX_SECTIONS && it.coef_select < NCOEF)
                    coef_q[it.stage_index][it.coef_select] = longint'(it.coef_value);
            biq_pkg::FUNC_CLEAR:
                for (s = 0; s < MAX_SECTIONS; s++)
                begin
                    dly_one[s] = 0;
                    dly_two[s] = 0;
                end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic biq_item_t mk_item(input logic [FUNC_W-1:0] f,
                                          input logic [SAMPLE_BITS-1:0] x,
                                          input logic [STAGE_W-1:0] st,
                                          input logic [SEL_W-1:0] sel,
                                          input logic [COEF_BITS-1:0] c);
        biq_item_t it;
        it.func        = f;
        it.sample_in   = x;
        it.stage_index = st;
        it.coef_select = sel;
        it.coef_value  = c;
        return it;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 2))
            0:       return SAMPLE_BITS'($urandom);
            1:       return SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
            default: return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    // coefficient of a section that stays inside the stability triangle
    function automatic logic [COEF_BITS-1:0] stable_coef(input biq_pkg::op_t op,
                                                        input int a2);
        int bound;
        case (op)
            biq_pkg::OP_A2:
                return COEF_BITS'(a2);
            biq_pkg::OP_A1:
            begin
                bound = ((1 << CFRAC) + a2) / 16 * 15;
                return COEF_BITS'(int'($urandom_range(0, 2 * bound)) - bound);
            end
            default:
                return COEF_BITS'(int'($urandom_range(0, 1572864)) - 786432);
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // offers one transaction in bursts with random gaps, applies it when taken
    task automatic send_item(input biq_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, it.coef_value, it.coef_select,
                     it.stage_index, it.sample_in};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_item(it);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
        send_item(mk_item(biq_pkg::FUNC_SAMPLE, x, '0, '0, '0));
    endtask

    task automatic send_coef(input int st, input logic [SEL_W-1:0] sel,
                             input logic [COEF_BITS-1:0] c);
        send_item(mk_item(biq_pkg::FUNC_COEF, rand_sample(), STAGE_W'(st), sel, c));
    endtask

    task automatic send_kind(input logic [FUNC_W-1:0] f);
        send_item(mk_item(f, SAMPLE_BITS'($urandom), STAGE_W'($urandom), SEL_W'($urandom),
                          COEF_BITS'($urandom)));
    endtask

    // stops offering and lets every expected result and any work in flight drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_stages(input logic [CFG_W-1:0] n);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        stages_cfg = n;
    endtask

    task automatic program_section(input int st, input bit noisy);
        int a2;
        a2 = int'($urandom_range(0, 1468006)) - 524288;
        for (int op = biq_pkg::OP_B0; op <= biq_pkg::OP_A2; op++)
            send_coef(st, SEL_W'(op),
                      noisy ? COEF_BITS'($urandom) : stable_coef(biq_pkg::op_t'(op), a2));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_pass_through();
        set_stages('0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample('0);
        send_sample('1);
        send_kind(FUNC_UNUSED);
        send_sample(16'sd1);
        send_kind(biq_pkg::FUNC_CLEAR);
    endtask

    task automatic test_coef_extremes();
        set_stages(4'd1);
        // largest gain saturates the output, smallest is exact
        send_coef(0, biq_pkg::OP_B0, 24'h7fffff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd100);
        send_coef(0, biq_pkg::OP_B0, 24'h800000);
        send_sample(16'sd1000);
        // a write with a selector past a2 must leave the section alone
        send_coef(0, SEL_BAD_HI, 24'h123456);
        send_coef(0, SEL_BAD_LO, 24'h7fffff);
        send_sample(-16'sd1000);
        // extreme feedback drives the internal words into saturation
        send_coef(0, biq_pkg::OP_A1, 24'h800000);
        send_coef(0, biq_pkg::OP_A2, 24'h7fffff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_kind(biq_pkg::FUNC_CLEAR);
        send_sample(16'sd5);
    endtask

    task automatic test_section_limit();
        // counts above the section count behave as all sections
        set_stages(STAGES_TOP);
        send_coef(0, biq_pkg::OP_B0, COEF_BITS'(Q_ONE));
        send_coef(0, biq_pkg::OP_A1, '0);
        send_coef(0, biq_pkg::OP_A2, '0);
        send_coef(7, biq_pkg::OP_B0, 24'h200000);
        send_sample(16'sh7fff);
        send_sample(16'sd1234);
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] plan [14] = '{4'd1, 4'd8, 4'd2, 4'd3, 4'd15, 4'd4, 4'd5,
                                        4'd6, 4'd7, 4'd0, 4'd8, 4'd9, 4'd1, 4'd12};
        int  nsec;
        int  roll;
        bit  noisy;
        for (int p = 0; p < 14; p++)
        begin
            set_stages(plan[p]);
            noisy = (p == 5 || p == 11);
            nsec  = (plan[p] > MAX_SECTIONS) ? MAX_SECTIONS : int'(plan[p]);
            if (nsec == 0)
                nsec = 1;
            send_kind(biq_pkg::FUNC_CLEAR);
            for (int s = 0; s < nsec; s++)
                program_section(s, noisy);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 84)
                    send_sample(rand_sample());
                else if (roll < 90)
                    send_coef($urandom_range(0, MAX_SECTIONS - 1),
                              SEL_W'($urandom_range(biq_pkg::OP_B0, biq_pkg::OP_B2)),
                              stable_coef(biq_pkg::OP_B0, 0));
                else if (roll < 93)
                    send_coef($urandom_range(0, MAX_SECTIONS - 1), SEL_W'($urandom),
                              COEF_BITS'($urandom));
                else if (roll < 97)
                    send_kind(biq_pkg::FUNC_CLEAR);
                else
                    send_kind(FUNC_UNUSED);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        fail_count = 0;
        burst_left = 0;
        reset_filter_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_coef_extremes();
        test_section_limit();
        test_random_phases();

        wait_idle();
        if (fail_count == 0)
            $display("** biquad_cascade_iir_filter: PASSED **");
        else
            $display("** biquad_cascade_iir_filter: FAILED **");
        $finish;
    end

    // receiver readiness follows segments of random mode and length
    initial
    begin
        rx_mode_t mode;
        int       len;
        m_tready <= 1'b0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(RX_OPEN, RX_MOSTLY));
            len  = $urandom_range(4, 48);
            repeat (len)
            begin
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // result checker: each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        biq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("unexpected result: sample_out=%0d clipped=%0b",
                       $signed(m_tdata[SAMPLE_BITS-1:0]), m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== want.sample_out)
                begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           $signed(want.sample_out), $signed(m_tdata[SAMPLE_BITS-1:0]));
                    fail_count++;
                end
                if (m_tuser !== want.clipped)
                begin
                    $error("clipped mismatch: expected %0b, actual %0b",
                           want.clipped, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** biquad_cascade_iir_filter: FAILED **");
                $finish;
            end
        end
    end

endmodule
